>>> hdl/bpts_pkg.sv
// Shared types and constants for the Blinn-Phong toon vertex shader.
`timescale 1ns / 1ps
package bpts_pkg;
   localparam logic [15:0] ONE_Q14 = 16'd16384;
   localparam logic [14:0] HALF_Q14 = 15'd8192;

   localparam logic [2:0] MODE_DIFFUSE  = 3'd0;
   localparam logic [2:0] MODE_TOON     = 3'd1;
   localparam logic [2:0] MODE_SPECULAR = 3'd2;
   localparam logic [2:0] MODE_COMBINED = 3'd3;

   localparam logic [2:0] REG_SHADE_MODE = 3'd0;
   localparam logic [2:0] REG_LIGHT_X    = 3'd1;
   localparam logic [2:0] REG_LIGHT_Y    = 3'd2;
   localparam logic [2:0] REG_LIGHT_Z    = 3'd3;
   localparam logic [2:0] REG_CAM_X      = 3'd4;
   localparam logic [2:0] REG_CAM_Y      = 3'd5;
   localparam logic [2:0] REG_CAM_Z      = 3'd6;

   localparam logic [1:0] KIND_ITEM  = 2'd0;
   localparam logic [1:0] KIND_LIGHT = 2'd1;
   localparam logic [1:0] KIND_CAM   = 2'd2;
   localparam logic [1:0] KIND_HALF  = 2'd3;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rsp_type;

   typedef logic signed [16:0] comp_type;

   typedef struct packed {
      logic [1:0] kind;
      comp_type   x;
      comp_type   y;
      comp_type   z;
   } vec_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } unit_type;

   typedef struct packed {
      logic [1:0] kind;
      unit_type   u;
   } unit_out_type;

   typedef struct packed {
      logic     cam_done;
      logic     half_done;
      comp_type hx;
      comp_type hy;
      comp_type hz;
   } setup_type;
endpackage

>>> hdl/vertex_blinn_phong_toon_shader.sv
// Top level of the Blinn-Phong toon vertex shader.
// Channel   Ports                          Moves
// request   req_valid req_stall req_data   one item: vertex normal
// response  rsp_valid rsp_stall rsp_data   one item: red, green, blue
// config    csr_we csr_index csr_wdata     one register write
// One item per cycle sustained while neither setup nor a stalled response holds the flow; the
// normalizer uses a one-bit-per-stage square root (30 stages) and divider (15 stages).
// After reset and after each register write, the setup sequencer derives the light,
// view and half vectors through the same normalizer; req_stall is high meanwhile.
// A stalled response freezes the pipeline; a two-item queue keeps taking items
// meanwhile until it is full.
`timescale 1ns / 1ps
module vertex_blinn_phong_toon_shader import bpts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   logic adv, head_valid, unit_valid;
   vec_type head;
   logic [2:0] mode;
   setup_type setup;
   unit_out_type unit_data;

   bpts_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pop(adv), .head_valid(head_valid), .head(head),
      .mode(mode), .setup(setup)
   );

   bpts_unit u_unit (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(head_valid), .in_vec(head),
      .out_valid(unit_valid), .out_data(unit_data)
   );

   bpts_back u_back (
      .clock(clock), .reset(reset), .rsp_stall(rsp_stall), .mode(mode),
      .unit_valid(unit_valid), .unit_data(unit_data),
      .adv(adv), .setup(setup),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   a_write_stalls: assert property (@(posedge clock) disable iff (reset)
      $past(csr_we) |-> req_stall)
      else $error("request not stalled after register write");

   a_half_while_busy: assert property (@(posedge clock) disable iff (reset)
      setup.half_done |-> req_stall)
      else $error("half vector finished outside setup");

   a_cam_while_busy: assert property (@(posedge clock) disable iff (reset)
      setup.cam_done |-> req_stall)
      else $error("view vector finished outside setup");
endmodule

>>> hdl/bpts_front.sv
// Front end: registers, setup sequencer and the item queue toward the shading pipeline.
`timescale 1ns / 1ps
module bpts_front import bpts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      csr_we,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_wdata,
   input  logic      pop,
   output logic      head_valid,
   output vec_type   head,
   output logic [2:0] mode,
   input  setup_type setup
);
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_LIGHT     = 3'd1;
   localparam logic [2:0] ST_CAM       = 3'd2;
   localparam logic [2:0] ST_WAIT_CAM  = 3'd3;
   localparam logic [2:0] ST_HALF      = 3'd4;
   localparam logic [2:0] ST_WAIT_HALF = 3'd5;

   logic [2:0] mode_ff;
   logic signed [15:0] lx_ff, ly_ff, lz_ff, cx_ff, cy_ff, cz_ff;
   logic [2:0] state_ff, state_in;
   logic dirty_ff, dirty_in;
   vec_type mem_ff [0:1];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic full, push, busy;
   vec_type push_vec;

   assign busy = (state_ff != ST_IDLE);
   assign full = (count_ff == 2'd2);
   assign req_stall = busy | full | csr_we;
   assign head_valid = (count_ff != 2'd0);
   assign head = mem_ff[rd_ptr_ff];
   assign mode = mode_ff;

   always_comb begin
      push = 1'b0;
      push_vec = '0;
      state_in = state_ff;
      dirty_in = dirty_ff | (csr_we & busy);
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               state_in = ST_LIGHT;
            end else if (req_valid && !full) begin
               push = 1'b1;
               push_vec = {KIND_ITEM, 17'(req_data.normal_x), 17'(req_data.normal_y),
                           17'(req_data.normal_z)};
            end
         end
         ST_LIGHT: begin
            if (!full) begin
               push = 1'b1;
               push_vec = {KIND_LIGHT, 17'(lx_ff), 17'(ly_ff), 17'(lz_ff)};
               state_in = ST_CAM;
            end
         end
         ST_CAM: begin
            if (!full) begin
               push = 1'b1;
               push_vec = {KIND_CAM, 17'(cx_ff), 17'(cy_ff), 17'(cz_ff)};
               state_in = ST_WAIT_CAM;
            end
         end
         ST_WAIT_CAM: begin
            if (setup.cam_done) begin
               state_in = ST_HALF;
            end
         end
         ST_HALF: begin
            if (!full) begin
               push = 1'b1;
               push_vec = {KIND_HALF, setup.hx, setup.hy, setup.hz};
               state_in = ST_WAIT_HALF;
            end
         end
         ST_WAIT_HALF: begin
            if (setup.half_done) begin
               state_in = (dirty_ff || csr_we) ? ST_LIGHT : ST_IDLE;
               dirty_in = 1'b0;
            end
         end
         default: state_in = ST_LIGHT;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (push && !(pop && head_valid)) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop && head_valid) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LIGHT;
         dirty_ff <= 1'b0;
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         mode_ff <= MODE_DIFFUSE;
         lx_ff <= 16'sd0;
         ly_ff <= 16'sd0;
         lz_ff <= 16'sd12288;
         cx_ff <= 16'sd0;
         cy_ff <= 16'sd0;
         cz_ff <= -16'sd16384;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop && head_valid) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (csr_we) begin
            case (csr_index)
               REG_SHADE_MODE: mode_ff <= csr_wdata[2:0];
               REG_LIGHT_X:    lx_ff <= csr_wdata;
               REG_LIGHT_Y:    ly_ff <= csr_wdata;
               REG_LIGHT_Z:    lz_ff <= csr_wdata;
               REG_CAM_X:      cx_ff <= csr_wdata;
               REG_CAM_Y:      cy_ff <= csr_wdata;
               REG_CAM_Z:      cz_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_vec;
      end
   end
endmodule

>>> hdl/bpts_unit.sv
// Pipelined vector normalizer: squares, one-bit-per-stage square root and divide.
`timescale 1ns / 1ps
module bpts_unit import bpts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  vec_type      in_vec,
   output logic         out_valid,
   output unit_out_type out_data
);
   localparam int SqrtSteps = 30;
   localparam int SumPairs = 16;
   localparam int DivSteps = 15;

   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic [2:0]       neg;
      logic [2:0][15:0] m;
   } abs_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic [2:0]       neg;
      logic [2:0][15:0] m;
      logic [2:0][30:0] sq;
   } sqr_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic [2:0]       neg;
      logic [2:0][15:0] m;
      logic             zero;
      logic [31:0]      s;
      logic [31:0]      rem;
      logic [29:0]      root;
   } sq_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic [2:0]       neg;
      logic             zero;
      logic [29:0]      len;
      logic [2:0][29:0] rem;
      logic [2:0][14:0] low;
      logic [2:0][14:0] q;
   } dv_type;

   abs_type abs_ff, abs_in;
   sqr_type sqr_ff, sqr_in;
   sq_type  sq_ff [0:SqrtSteps];
   sq_type  sq_in [0:SqrtSteps];
   dv_type  dv_ff [0:DivSteps];
   dv_type  dv_in [0:DivSteps];
   logic    out_valid_ff;
   unit_out_type out_ff, out_in;
   logic [2:0][16:0] comp;

   assign comp = {in_vec.x, in_vec.y, in_vec.z};

   always_comb begin
      abs_in.valid = in_valid;
      abs_in.kind = in_vec.kind;
      for (int i = 0; i < 3; i++) begin
         abs_in.neg[i] = comp[i][16];
         abs_in.m[i] = comp[i][16] ? 16'(-comp[i]) : comp[i][15:0];
      end
   end

   always_comb begin
      sqr_in.valid = abs_ff.valid;
      sqr_in.kind = abs_ff.kind;
      sqr_in.neg = abs_ff.neg;
      sqr_in.m = abs_ff.m;
      for (int i = 0; i < 3; i++) begin
         sqr_in.sq[i] = 31'(32'(abs_ff.m[i]) * 32'(abs_ff.m[i]));
      end
   end

   always_comb begin
      sq_in[0].valid = sqr_ff.valid;
      sq_in[0].kind = sqr_ff.kind;
      sq_in[0].neg = sqr_ff.neg;
      sq_in[0].m = sqr_ff.m;
      sq_in[0].s = 32'(sqr_ff.sq[0]) + 32'(sqr_ff.sq[1]) + 32'(sqr_ff.sq[2]);
      sq_in[0].zero = (sqr_ff.sq == '0);
      sq_in[0].rem = '0;
      sq_in[0].root = '0;
   end

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      logic [1:0] pair;
      logic [33:0] r2, trial;
      if (k < SumPairs) begin : g_hi
         assign pair = sq_ff[k].s[31-2*k -: 2];
      end else begin : g_lo
         assign pair = 2'b00;
      end
      always_comb begin
         r2 = {sq_ff[k].rem, pair};
         trial = {2'b00, sq_ff[k].root, 2'b01};
         sq_in[k+1] = sq_ff[k];
         if (r2 >= trial) begin
            sq_in[k+1].rem = 32'(r2 - trial);
            sq_in[k+1].root = {sq_ff[k].root[28:0], 1'b1};
         end else begin
            sq_in[k+1].rem = r2[31:0];
            sq_in[k+1].root = {sq_ff[k].root[28:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic [43:0] d;
      dv_in[0].valid = sq_ff[SqrtSteps].valid;
      dv_in[0].kind = sq_ff[SqrtSteps].kind;
      dv_in[0].neg = sq_ff[SqrtSteps].neg;
      dv_in[0].zero = sq_ff[SqrtSteps].zero;
      dv_in[0].len = sq_ff[SqrtSteps].root;
      dv_in[0].q = '0;
      for (int i = 0; i < 3; i++) begin
         d = {sq_ff[SqrtSteps].m[i], 28'd0} + 44'(sq_ff[SqrtSteps].root >> 1);
         dv_in[0].rem[i] = 30'(d[43:15]);
         dv_in[0].low[i] = d[14:0];
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      always_comb begin
         logic [30:0] r2;
         dv_in[k+1] = dv_ff[k];
         for (int i = 0; i < 3; i++) begin
            r2 = {dv_ff[k].rem[i], dv_ff[k].low[i][14]};
            dv_in[k+1].low[i] = {dv_ff[k].low[i][13:0], 1'b0};
            if (r2 >= {1'b0, dv_ff[k].len}) begin
               dv_in[k+1].rem[i] = 30'(r2 - {1'b0, dv_ff[k].len});
               dv_in[k+1].q[i] = {dv_ff[k].q[i][13:0], 1'b1};
            end else begin
               dv_in[k+1].rem[i] = r2[29:0];
               dv_in[k+1].q[i] = {dv_ff[k].q[i][13:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      logic [2:0][15:0] res;
      logic [15:0] qc;
      for (int i = 0; i < 3; i++) begin
         qc = (16'(dv_ff[DivSteps].q[i]) > ONE_Q14) ? ONE_Q14 : 16'(dv_ff[DivSteps].q[i]);
         if (dv_ff[DivSteps].zero) begin
            res[i] = 16'd0;
         end else begin
            res[i] = dv_ff[DivSteps].neg[i] ? -qc : qc;
         end
      end
      out_in.kind = dv_ff[DivSteps].kind;
      out_in.u = {res[2], res[1], res[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_ff.valid <= 1'b0;
         sqr_ff.valid <= 1'b0;
         for (int i = 0; i <= SqrtSteps; i++) begin
            sq_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i <= DivSteps; i++) begin
            dv_ff[i].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         abs_ff <= abs_in;
         sqr_ff <= sqr_in;
         for (int i = 0; i <= SqrtSteps; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         for (int i = 0; i <= DivSteps; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         out_valid_ff <= dv_ff[DivSteps].valid;
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data = out_ff;
endmodule

>>> hdl/bpts_back.sv
// Back end: unit vector capture, dot products, power 20, mode select and result register.
`timescale 1ns / 1ps
module bpts_back import bpts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_stall,
   input  logic [2:0]   mode,
   input  logic         unit_valid,
   input  unit_out_type unit_data,
   output logic         adv,
   output setup_type    setup,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   function automatic logic [14:0] clamped_dot(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
      logic signed [33:0] sum;
      logic [33:0] t;
      begin
         sum = 34'(a) + 34'(b) + 34'(c);
         t = (34'(sum) + 34'(HALF_Q14)) >> 14;
         if (sum <= 0) begin
            clamped_dot = 15'd0;
         end else if (t > 34'(ONE_Q14)) begin
            clamped_dot = 15'(ONE_Q14);
         end else begin
            clamped_dot = t[14:0];
         end
      end
   endfunction

   function automatic logic [14:0] qmul(input logic [14:0] a, input logic [14:0] b);
      logic [30:0] p;
      begin
         p = 31'(a) * 31'(b) + 31'(HALF_Q14);
         qmul = p[28:14];
      end
   endfunction

   unit_type lu_ff, vu_ff, hu_ff, nu;
   logic item;
   logic p0_v_ff, p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff, p6_v_ff;
   logic signed [31:0] ld0_ff, ld1_ff, ld2_ff, hd0_ff, hd1_ff, hd2_ff;
   logic [14:0] di1_ff, di2_ff, di3_ff, di4_ff, di5_ff, di6_ff;
   logic [14:0] x1_ff, x2_ff, x4_ff, x4b_ff, x4c_ff, x8_ff, x16_ff, si6_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic [15:0] val, di_w, si_w;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign nu = unit_data.u;
   assign item = unit_valid && (unit_data.kind == KIND_ITEM);

   assign setup.cam_done = adv && unit_valid && (unit_data.kind == KIND_CAM);
   assign setup.half_done = adv && unit_valid && (unit_data.kind == KIND_HALF);
   assign setup.hx = 17'(lu_ff.x) + 17'(vu_ff.x);
   assign setup.hy = 17'(lu_ff.y) + 17'(vu_ff.y);
   assign setup.hz = 17'(lu_ff.z) + 17'(vu_ff.z);

   always_comb begin
      di_w = 16'(di6_ff);
      si_w = 16'(si6_ff);
      val = 16'd0;
      rsp_in = '0;
      case (mode)
         MODE_DIFFUSE:  val = di_w;
         MODE_TOON:     val = ((di_w < 16'(HALF_Q14)) ? 16'd0 : 16'(HALF_Q14))
                              + ((si_w < 16'(HALF_Q14)) ? 16'd0 : ONE_Q14);
         MODE_SPECULAR: val = si_w;
         MODE_COMBINED: val = di_w + si_w;
         default:       val = 16'd0;
      endcase
      if (mode == MODE_DIFFUSE || mode == MODE_TOON || mode == MODE_SPECULAR
          || mode == MODE_COMBINED) begin
         rsp_in = {val, val, val};
      end else begin
         rsp_in = {16'd0, ONE_Q14, 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
         p6_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p0_v_ff <= item;
         p1_v_ff <= p0_v_ff;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
         p6_v_ff <= p5_v_ff;
         rsp_valid_ff <= p6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (unit_valid && unit_data.kind == KIND_LIGHT) begin
            lu_ff <= nu;
         end
         if (unit_valid && unit_data.kind == KIND_CAM) begin
            vu_ff <= nu;
         end
         if (unit_valid && unit_data.kind == KIND_HALF) begin
            hu_ff <= nu;
         end
         ld0_ff <= lu_ff.x * nu.x;
         ld1_ff <= lu_ff.y * nu.y;
         ld2_ff <= lu_ff.z * nu.z;
         hd0_ff <= hu_ff.x * nu.x;
         hd1_ff <= hu_ff.y * nu.y;
         hd2_ff <= hu_ff.z * nu.z;
         di1_ff <= clamped_dot(ld0_ff, ld1_ff, ld2_ff);
         x1_ff <= clamped_dot(hd0_ff, hd1_ff, hd2_ff);
         di2_ff <= di1_ff;
         x2_ff <= qmul(x1_ff, x1_ff);
         di3_ff <= di2_ff;
         x4_ff <= qmul(x2_ff, x2_ff);
         di4_ff <= di3_ff;
         x4b_ff <= x4_ff;
         x8_ff <= qmul(x4_ff, x4_ff);
         di5_ff <= di4_ff;
         x4c_ff <= x4b_ff;
         x16_ff <= qmul(x8_ff, x8_ff);
         di6_ff <= di5_ff;
         si6_ff <= qmul(x16_ff, x4c_ff);
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

>>> tb/tb_vertex_blinn_phong_toon_shader.sv
// Testbench for the Blinn-Phong toon vertex shader: directed and random normals checked against a predictor.
`timescale 1ns / 1ps
module tb_vertex_blinn_phong_toon_shader import bpts_pkg::*; ();

   localparam int LATENCY = 200;
   localparam int LONG_HOLD = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   logic [2:0]         cur_mode;
   logic signed [15:0] light_pos [3];
   logic signed [15:0] cam_pos [3];

   rsp_type expected_colors [$];
   int      error_count = 0;
   int      hold_cycles = 0;
   int      hold_requests = 0;
   int      hold_served = 0;
   int      stall_chance;

   vertex_blinn_phong_toon_shader u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic void normalize(input longint v [3], output longint u [3]);
      logic [63:0] sumsq;
      logic [63:0] len;
      logic [63:0] q;
      logic [63:0] m;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         m = v[i] < 0 ? -v[i] : v[i];
         sumsq += m * m;
      end
      if (sumsq == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
      end else begin
         len = int_sqrt(sumsq << 28);
         for (int i = 0; i < 3; i++) begin
            m = v[i] < 0 ? -v[i] : v[i];
            q = ((m << 28) + (len >> 1)) / len;
            if (q > ONE_Q14) q = ONE_Q14;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
         end
      end
   endfunction

   function automatic longint clamp_dot(input longint a [3], input longint b [3]);
      longint s;
      longint t;
      s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      if (s <= 0) return 0;
      t = (s + HALF_Q14) >>> 14;
      return t > ONE_Q14 ? longint'(ONE_Q14) : t;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + HALF_Q14) >>> 14;
   endfunction

   function automatic rsp_type shade(input req_type n);
      longint nv [3], lv [3], vv [3], hv [3];
      longint nu [3], lu [3], vu [3], hu [3];
      longint di, x, x2, x4, x8, x16, si, val;
      rsp_type r;
      nv[0] = n.normal_x;
      nv[1] = n.normal_y;
      nv[2] = n.normal_z;
      for (int i = 0; i < 3; i++) begin
         lv[i] = light_pos[i];
         vv[i] = cam_pos[i];
      end
      normalize(nv, nu);
      normalize(lv, lu);
      normalize(vv, vu);
      for (int i = 0; i < 3; i++) hv[i] = vu[i] + lu[i];
      normalize(hv, hu);
      di = clamp_dot(lu, nu);
      x = clamp_dot(hu, nu);
      x2 = qmul(x, x);
      x4 = qmul(x2, x2);
      x8 = qmul(x4, x4);
      x16 = qmul(x8, x8);
      si = qmul(x16, x4);
      case (cur_mode)
         MODE_DIFFUSE: val = di;
         MODE_TOON: val = (di < HALF_Q14 ? 0 : HALF_Q14) + (si < HALF_Q14 ? 0 : ONE_Q14);
         MODE_SPECULAR: val = si;
         MODE_COMBINED: val = di + si;
         default: val = -1;
      endcase
      if (val < 0) begin
         r.red = 0;
         r.green = ONE_Q14;
         r.blue = 0;
      end else begin
         r.red = val[15:0];
         r.green = val[15:0];
         r.blue = val[15:0];
      end
      return r;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_SHADE_MODE: cur_mode = value[2:0];
         REG_LIGHT_X: light_pos[0] = value;
         REG_LIGHT_Y: light_pos[1] = value;
         REG_LIGHT_Z: light_pos[2] = value;
         REG_CAM_X: cam_pos[0] = value;
         REG_CAM_Y: cam_pos[1] = value;
         REG_CAM_Z: cam_pos[2] = value;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (expected_colors.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic send_normal(input req_type n);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_valid = 1'b1;
      req_data = n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_colors = {expected_colors, shade(n)};
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic req_type random_normal();
      req_type n;
      case ($urandom_range(0, 3))
         0: n = {16'($urandom), 16'($urandom), 16'($urandom)};
         1: n = {16'($urandom_range(0, 32767) - 16384), 16'($urandom_range(0, 32767) - 16384),
                 16'($urandom_range(0, 32767) - 16384)};
         2: n = {16'($urandom_range(0, 8191) - 4096), 16'($urandom_range(0, 8191) - 4096),
                 16'($urandom_range(0, 32767))};
         default: n = {16'($urandom_range(0, 2047) - 1024), 16'($urandom_range(0, 2047) - 1024),
                       -16'($urandom_range(8192, 32768))};
      endcase
      return n;
   endfunction

   task automatic test_directed;
      req_type list [$];
      list = '{ '{16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd16384},
                '{16'sd0, 16'sd0, -16'sd16384}, '{-16'sd32768, -16'sd32768, -16'sd32768},
                '{16'sd32767, 16'sd32767, 16'sd32767}, '{16'sd32767, -16'sd32768, 16'sd1},
                '{16'sd1, 16'sd0, 16'sd0}, '{16'sd0, -16'sd1, 16'sd0},
                '{16'sd0, 16'sd0, -16'sd32768}, '{16'sd5000, 16'sd5000, 16'sd5000} };
      for (int m = 0; m < 8; m++) begin
         write_reg(REG_SHADE_MODE, 16'(m));
         foreach (list[i]) send_normal(list[i]);
         drain();
      end
   endtask

   task automatic test_special_vectors;
      write_reg(REG_SHADE_MODE, 16'(MODE_COMBINED));
      write_reg(REG_LIGHT_X, 16'd0);
      write_reg(REG_LIGHT_Y, 16'd0);
      write_reg(REG_LIGHT_Z, 16'd0);
      for (int i = 0; i < 6; i++) send_normal(random_normal());
      drain();
      write_reg(REG_LIGHT_Z, 16'd12288);
      write_reg(REG_CAM_Z, 16'd0);
      for (int i = 0; i < 6; i++) send_normal(random_normal());
      drain();
      write_reg(REG_CAM_Z, 16'hC000);
      write_reg(REG_LIGHT_Z, 16'h4000);
      for (int i = 0; i < 6; i++) send_normal(random_normal());
      drain();
   endtask

   task automatic test_random_settings;
      for (int phase = 0; phase < 18; phase++) begin
         write_reg(REG_SHADE_MODE, 16'($urandom_range(0, phase % 6 == 5 ? 7 : 3)));
         for (int k = 0; k < 3; k++) begin
            write_reg(3'(REG_LIGHT_X + k), phase == 0 ? 16'h8000 : phase == 1 ? 16'h7FFF :
                      16'($urandom));
            write_reg(3'(REG_CAM_X + k), phase == 0 ? 16'h7FFF : phase == 1 ? 16'h8000 :
                      16'($urandom));
         end
         if (phase % 3 == 0) write_reg(3'(REG_CAM_Z + 3'd1), 16'($urandom));
         stall_chance = phase % 4 == 0 ? 0 : 30;
         for (int i = 0; i < 90; i++) send_normal(random_normal());
         drain();
      end
      stall_chance = 30;
   endtask

   task automatic test_backpressure;
      hold_requests++;
      for (int i = 0; i < 130; i++) send_normal(random_normal());
      drain();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type e;
            e = expected_colors.pop_front();
            if (rsp_data.red !== e.red)
               $display("%0t red expected %0d actual %0d", $time, e.red, rsp_data.red);
            if (rsp_data.green !== e.green)
               $display("%0t green expected %0d actual %0d", $time, e.green, rsp_data.green);
            if (rsp_data.blue !== e.blue)
               $display("%0t blue expected %0d actual %0d", $time, e.blue, rsp_data.blue);
            if (rsp_data !== e) error_count++;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         rsp_stall <= 1'b1;
         hold_cycles <= LONG_HOLD;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if ($urandom_range(0, 99) < stall_chance) begin
         rsp_stall <= 1'b1;
         if ($urandom_range(0, 40) == 0) hold_cycles <= $urandom_range(10, 60);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #50_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      stall_chance = 30;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cur_mode = MODE_DIFFUSE;
      light_pos = '{16'sd0, 16'sd0, 16'sd12288};
      cam_pos = '{16'sd0, 16'sd0, -16'sd16384};
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_special_vectors();
      test_backpressure();
      test_random_settings();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
